>>> rtl/twar_pkg.sv
// twar_pkg: shared types and constants of the tick weighted averaging resampler.
// No dependencies; every other file of the block but twar_queue imports it.
`default_nettype none

package twar_pkg;

    // Field widths
    localparam int LEVEL_W  = 20;
    localparam int TICKS_W  = 10;
    localparam int SHARES_W = 4;
    localparam int SAMPLE_W = 16;
    localparam int CPS_W    = 32;

    // Internal widths
    localparam int PHASE_W  = 33;
    localparam int SUM_W    = 48;
    localparam int TOTAL_W  = 26;
    localparam int PROD_W   = LEVEL_W + TICKS_W + 1;   // level * ticks, signed
    localparam int SHR_W    = 5;                       // saturated shares, up to MAX_SOURCES + 1
    localparam int DIV_W    = TOTAL_W + SHR_W;         // tick_total * shares

    // Samples per item, at most
    localparam int MAX_OUT  = 64;
    localparam int CNT_W    = $clog2(MAX_OUT);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CPS_W-1:0] MIN_CPS   = 32'd4096;
    localparam logic [CPS_W-1:0] CPS_RESET = 32'd11609;

    // Register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CPS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE = 1'b1;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [TICKS_W-1:0]        ticks;
        logic [SHARES_W-1:0]       shares;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } result_t;

    // Classified request as it sits in the queue
    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic [TICKS_W-1:0]       ticks;
        logic [SHR_W-1:0]         shares;
    } entry_t;

    typedef struct packed {
        logic [CPS_W-1:0] cps;
        logic             mute;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic div_busy;
    } bstat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/twar_front.sv
// twar_front: classifies an incoming request (share saturation, level * ticks).
// Depends on twar_pkg.
`default_nettype none

module twar_front #(
    parameter int MAX_SOURCES = 8
) (
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire twar_pkg::item_t  item,
    input  wire logic             q_full,
    output logic                  push,
    output twar_pkg::entry_t      entry
);
    import twar_pkg::*;

    localparam logic [SHR_W-1:0] SHARE_CAP = SHR_W'(MAX_SOURCES + 1);

    logic [SHR_W-1:0] shares_sat;

    // Zero shares count as one, too many saturate
    always_comb
    begin
        shares_sat = {1'b0, item.shares};
        priority if (shares_sat == '0)
        begin
            shares_sat = SHR_W'(1);
        end
        else if (shares_sat > SHARE_CAP)
        begin
            shares_sat = SHARE_CAP;
        end
    end

    // Weighted level and queue entry
    always_comb
    begin
        entry.prod   = item.level * $signed({1'b0, item.ticks});
        entry.ticks  = item.ticks;
        entry.shares = shares_sat;
    end

    assign item_ready = !q_full;
    assign push       = item_valid && !q_full;

endmodule

`default_nettype wire

>>> rtl/twar_queue.sv
// twar_queue: small FIFO between front and back.
// Depends on nothing; DEPTH must be a power of two of at least two.
`default_nettype none

module twar_queue #(
    parameter int DEPTH = 2,
    parameter int W     = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wdata,
    input  wire logic         pop,
    output logic [W-1:0]      rdata,
    output logic              full,
    output logic              valid
);
    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [LW-1:0] count_reg;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + LW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - LW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == LW'(DEPTH));
    assign valid = (count_reg != '0);

endmodule

`default_nettype wire

>>> rtl/twar_div.sv
// twar_div: restoring divider, one quotient bit per cycle, with signed 16-bit clamp.
// Depends on twar_pkg.
`default_nettype none

module twar_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          neg,
    input  wire logic [twar_pkg::SUM_W-1:0]    dividend,
    input  wire logic [twar_pkg::DIV_W-1:0]    divisor,
    output logic                               busy,
    output logic                               done,
    output logic signed [twar_pkg::SAMPLE_W-1:0] quot
);
    import twar_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);
    localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'(32767);
    localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'(32768);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  dq_reg;      // dividend shifts out, quotient shifts in
    logic [DIV_W-1:0]  dvs_reg;
    logic              neg_reg;

    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              ge;
    logic [DIV_W-1:0]  rem_next;
    logic [SUM_W-1:0]  dq_next;

    // One restoring step
    always_comb
    begin
        trial    = {rem_reg, dq_reg[SUM_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dq_next  = {dq_reg[SUM_W-2:0], ge};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    // Sign and clamp to 16 bits
    always_comb
    begin
        if (neg_reg)
        begin
            quot = (dq_reg > NEG_LIMIT) ? -16'sd32768 : -$signed(dq_reg[SAMPLE_W-1:0]);
        end
        else
        begin
            quot = (dq_reg > POS_LIMIT) ? 16'sd32767 : $signed(dq_reg[SAMPLE_W-1:0]);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

>>> rtl/twar_back.sv
// twar_back: accumulates queued requests, runs the phase, divides and emits samples.
// Depends on twar_pkg and twar_div.
`default_nettype none

module twar_back #(
    parameter int PHASE_FRAC_BITS = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire twar_pkg::cfg_t   cfg,
    input  wire logic             q_valid,
    input  wire twar_pkg::entry_t q_entry,
    output logic                  q_pop,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output twar_pkg::result_t     result,
    output twar_pkg::bstat_t      status
);
    import twar_pkg::*;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [PHASE_W-1:0]       phase_reg;
    logic signed [SUM_W-1:0]  ws_reg;
    logic [TOTAL_W-1:0]       tt_reg;
    logic [SHR_W-1:0]         shares_reg;
    logic signed [SAMPLE_W-1:0] held_reg;
    logic                     last_reg;
    logic [CNT_W-1:0]         n_reg;
    logic                     res_valid_reg;
    result_t                  res_reg;

    logic [CPS_W-1:0]         cps_eff;
    logic [PHASE_W-1:0]       cps_ph;
    logic [PHASE_W-1:0]       adv;
    logic [PHASE_W-1:0]       phase_sub;
    logic                     fire;
    logic                     last_calc;
    logic                     out_free;
    logic                     div_start;
    logic                     load_res;
    logic                     ws_neg;
    logic [SUM_W-1:0]         ws_mag;
    logic [DIV_W-1:0]         dvs;
    logic                     div_busy;
    logic                     div_done;
    logic signed [SAMPLE_W-1:0] div_q;

    // Phase arithmetic
    always_comb
    begin
        cps_eff   = (cfg.cps < MIN_CPS) ? MIN_CPS : cfg.cps;
        cps_ph    = {1'b0, cps_eff};
        adv       = PHASE_W'(q_entry.ticks) << PHASE_FRAC_BITS;
        fire      = (phase_reg >= cps_ph);
        phase_sub = phase_reg - cps_ph;
        last_calc = (phase_sub < cps_ph) || (n_reg == CNT_W'(MAX_OUT - 1));
        out_free  = !res_valid_reg || result_ready;
    end

    // Divider operands
    always_comb
    begin
        ws_neg = ws_reg[SUM_W-1];
        ws_mag = ws_neg ? SUM_W'(-ws_reg) : SUM_W'(ws_reg);
        dvs    = DIV_W'(tt_reg) * DIV_W'(shares_reg);
    end

    twar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .neg      (ws_neg),
        .dividend (ws_mag),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!fire)
                begin
                    state_next = ST_IDLE;
                end
                else if (tt_reg != '0)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_reg ? ST_IDLE : ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_pop     = (state_reg == ST_IDLE) && q_valid;
        div_start = (state_reg == ST_CHECK) && fire && (tt_reg != '0);
        load_res  = (state_reg == ST_EMIT) && out_free;
    end

    // State and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            ws_reg        <= '0;
            tt_reg        <= '0;
            held_reg      <= '0;
            n_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                ws_reg    <= ws_reg + SUM_W'(q_entry.prod);
                tt_reg    <= tt_reg + TOTAL_W'(q_entry.ticks);
                phase_reg <= phase_reg + adv;
                n_reg     <= '0;
            end
            else if ((state_reg == ST_CHECK) && fire)
            begin
                phase_reg <= phase_sub;
                ws_reg    <= '0;
                tt_reg    <= '0;
                n_reg     <= n_reg + CNT_W'(1);
            end
            if ((state_reg == ST_DIV) && div_done)
            begin
                held_reg <= div_q;
            end
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Per-request payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            shares_reg <= q_entry.shares;
        end
        if ((state_reg == ST_CHECK) && fire)
        begin
            last_reg <= last_calc;
        end
        if (load_res)
        begin
            res_reg.sample <= cfg.mute ? '0 : held_reg;
            res_reg.last   <= last_reg;
        end
    end

    assign result_valid    = res_valid_reg;
    assign result          = res_reg;
    assign status.idle     = (state_reg == ST_IDLE);
    assign status.div_busy = div_busy;

endmodule

`default_nettype wire

>>> rtl/tick_weighted_averaging_resampler.sv
// Tick weighted averaging resampler. Each request (level, ticks, shares) adds
// level*ticks and ticks to running sums and advances a fractional phase by
// ticks << PHASE_FRAC_BITS; every time the phase passes counts_per_sample one
// sample is emitted (at most 64 per request, last marks the final one). The
// first sample of a run is the sum over (ticks * shares), truncated toward
// zero and clamped to 16 bits; later samples of the run repeat it, and mute
// zeroes the output only. Requests enter a two-entry queue, one per cycle
// while it is not full, as the back end works. The back end takes a request
// in IDLE and checks the phase in CHECK; each sample then passes CHECK and
// EMIT, and the first sample of a run when ticks were seen also passes DIV:
// it goes through a one bit per cycle divider of the 48-bit sum. A finished
// sample waits in an output register, so the next request is taken while it
// is pending.
// Depends on twar_pkg, twar_front, twar_queue, twar_back (and twar_div).
`default_nettype none

module tick_weighted_averaging_resampler #(
    parameter int MAX_SOURCES     = 8,
    parameter int PHASE_FRAC_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire twar_pkg::item_t                   item,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output twar_pkg::result_t                      result,
    input  wire logic                              cfg_we,
    input  wire logic [twar_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [twar_pkg::CPS_W-1:0]        cfg_data
);
    import twar_pkg::*;

    localparam int ENTRY_W = $bits(entry_t);

    logic [CPS_W-1:0]   cps_reg;
    logic               mute_reg;
    cfg_t               cfg;
    logic               q_full;
    logic               q_valid;
    logic               push;
    logic               q_pop;
    entry_t             entry_in;
    entry_t             entry_out;
    logic [ENTRY_W-1:0] entry_bits;
    bstat_t             bstat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cps_reg  <= CPS_RESET;
            mute_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CPS:  cps_reg  <= cfg_data;
                REG_MUTE: mute_reg <= cfg_data[0];
                default:  ;
            endcase
        end
    end

    assign cfg.cps  = cps_reg;
    assign cfg.mute = mute_reg;

    twar_front #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .entry      (entry_in)
    );

    twar_queue #(
        .DEPTH (QUEUE_DEPTH),
        .W     (ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (entry_in),
        .pop   (q_pop),
        .rdata (entry_bits),
        .full  (q_full),
        .valid (q_valid)
    );

    assign entry_out = entry_t'(entry_bits);

    twar_back #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_entry      (entry_out),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .status       (bstat)
    );

    // The back end takes only what the queue holds
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // An accepted request is waiting in the queue in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> q_valid)
        else $error("accepted request lost before the back end");

    // The divider never runs while the back end is between requests
    assert property (@(posedge clk) disable iff (!rst_n) bstat.idle |-> !bstat.div_busy)
        else $error("divider busy with back end idle");

endmodule

`default_nettype wire

>>> test/tb_tick_weighted_averaging_resampler.sv
`timescale 1ns / 1ps
// Testbench for tick_weighted_averaging_resampler: a sample tracker class predicts every
// emitted sample from accepted requests and register writes, and checks results in order.
// Depends on twar_pkg and the resampler RTL only.

import twar_pkg::*;

// Predicts the samples each request emits and checks them as they come out
class sample_tracker;
    localparam int MAX_SHARES  = 8 + 1;
    localparam int PHASE_SHIFT = 8;

    logic [CPS_W-1:0]           cps;
    logic                       mute;
    logic [PHASE_W-1:0]         phase;
    logic signed [SUM_W-1:0]    wsum;
    logic [TOTAL_W-1:0]         tick_total;
    logic signed [SAMPLE_W-1:0] held;
    result_t                    expected_samples[$];
    int                         errors;
    int                         checked;

    function new();
        cps        = CPS_RESET;
        mute       = 1'b0;
        phase      = '0;
        wsum       = '0;
        tick_total = '0;
        held       = '0;
        errors     = 0;
        checked    = 0;
    endfunction

    function int pending();
        return expected_samples.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CPS_W-1:0] data);
        if (idx == REG_CPS)
            cps = data;
        else if (idx == REG_MUTE)
            mute = data[0];
    endfunction

    // Accumulate one request and queue the samples it emits
    function void predict_samples(item_t req);
        logic signed [SUM_W-1:0] prod;
        logic [SUM_W-1:0]        mag;
        logic [SUM_W-1:0]        quo;
        logic [DIV_W-1:0]        divisor;
        logic [SHR_W-1:0]        sh;
        logic [PHASE_W-1:0]      eff;
        logic                    neg;
        result_t                 r;
        int                      n;
        sh = (req.shares == '0) ? SHR_W'(1) : SHR_W'(req.shares);
        if (sh > SHR_W'(MAX_SHARES))
            sh = SHR_W'(MAX_SHARES);
        prod       = $signed(req.level) * $signed({1'b0, req.ticks});
        wsum       = wsum + prod;
        tick_total = tick_total + TOTAL_W'(req.ticks);
        phase      = phase + (PHASE_W'(req.ticks) << PHASE_SHIFT);
        eff        = (cps < MIN_CPS) ? PHASE_W'(MIN_CPS) : PHASE_W'(cps);
        n          = 0;
        while (phase >= eff && n < MAX_OUT) begin
            phase = phase - eff;
            // first sample of a run divides, the rest repeat the held value
            if (tick_total != '0) begin
                divisor = DIV_W'(tick_total) * DIV_W'(sh);
                neg     = wsum[SUM_W-1];
                mag     = neg ? (SUM_W'(0) - wsum) : wsum;
                quo     = mag / SUM_W'(divisor);
                if (!neg)
                    held = (quo > SUM_W'(32767)) ? 16'sh7FFF : quo[15:0];
                else
                    held = (quo > SUM_W'(32768)) ? 16'sh8000 : 16'(SUM_W'(0) - quo);
            end
            wsum       = '0;
            tick_total = '0;
            n++;
            r.sample = mute ? '0 : held;
            r.last   = !(phase >= eff && n < MAX_OUT);
            expected_samples = {expected_samples, r};
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch: %s", msg);
    endtask

    task check_sample(result_t got);
        result_t want;
        checked++;
        if (expected_samples.size() == 0) begin
            report($sformatf("sample %0d: unexpected, value %0d last %0b",
                             checked, got.sample, got.last));
            return;
        end
        want = expected_samples.pop_front();
        if (got.sample !== want.sample)
            report($sformatf("sample %0d: value %0d, expected %0d",
                             checked, got.sample, want.sample));
        if (got.last !== want.last)
            report($sformatf("sample %0d: last %0b, expected %0b",
                             checked, got.last, want.last));
    endtask
endclass

module tb_tick_weighted_averaging_resampler;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 16;

    typedef enum int { RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_MOSTLY } ready_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    item_t                item_bus = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result_bus;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CPS_W-1:0]     cfg_data = '0;
    logic                 hold_req = 1'b0;

    sample_tracker tracker = new();
    int            burst_left = 0;
    int            quiet = 0;
    int            hold_left = 0;
    int            mode_left = 0;
    ready_mode_t   ready_mode = RDY_ALWAYS;

    tick_weighted_averaging_resampler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor: register writes, accepted requests, returned samples, watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_we)
                tracker.write_reg(cfg_index, cfg_data);
            if (item_valid && item_ready)
                tracker.predict_samples(item_bus);
            if (result_valid && result_ready)
                tracker.check_sample(result_bus);
            if (cfg_we || (item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", quiet);
                $display("tb_tick_weighted_averaging_resampler failed");
                $finish;
            end
        end
    end

    // Receiver: random ready pattern, with a long hold-off when hold_req asks for one
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
            hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else begin
            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(10, 150);
            end
            mode_left--;
            case (ready_mode)
                RDY_ALWAYS: result_ready <= 1'b1;
                RDY_HALF:   result_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                default:    result_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic item_t make_request(int lvl, int tk, int sh);
        item_t req;
        req.level  = LEVEL_W'(lvl);
        req.ticks  = TICKS_W'(tk);
        req.shares = SHARES_W'(sh);
        return req;
    endfunction

    function automatic item_t random_request();
        item_t       req;
        logic [31:0] rnd;
        int          pick;
        rnd = $urandom();
        req.level = rnd[LEVEL_W-1:0];
        if ($urandom_range(0, 7) == 0)
            req.level = rnd[20] ? 20'sh7FFFF : 20'sh80000;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            req.ticks = '0;
        else if (pick <= 3)
            req.ticks = TICKS_W'($urandom_range(1, 63));
        else
            req.ticks = TICKS_W'($urandom_range(0, 1023));
        // mostly legal share counts, sometimes zero or oversized
        if ($urandom_range(0, 4) == 0)
            req.shares = SHARES_W'($urandom_range(0, 15));
        else
            req.shares = SHARES_W'($urandom_range(1, 9));
        return req;
    endfunction

    // Offer one request; called right after a rising edge
    task automatic offer_request(item_t req);
        int gap;
        item_valid <= 1'b1;
        item_bus   <= req;
        do @(posedge clk); while (!item_ready);
        if (burst_left > 0)
            burst_left--;
        else begin
            item_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 6);
        end
    endtask

    // Stop sending, wait until every sample is back, then let the block settle
    task automatic settle_block();
        item_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CPS_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] word;
        logic [31:0] cps_val;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes, truncation, share saturation at reset settings
        offer_request(make_request(524287, 1023, 1));
        offer_request(make_request(-524288, 1023, 0));
        offer_request(make_request(0, 0, 5));
        offer_request(make_request(-7, 100, 3));
        offer_request(make_request(100000, 500, 4));
        offer_request(make_request(-100000, 500, 15));
        offer_request(make_request(524287, 1023, 9));
        offer_request(make_request(1, 1, 10));
        offer_request(make_request(-1, 1023, 2));
        offer_request(make_request(12345, 45, 6));
        offer_request(make_request(-524288, 0, 1));

        // Sample period below the minimum
        settle_block();
        program_reg(REG_CPS, 32'd0);
        offer_request(make_request(300000, 1023, 7));
        offer_request(make_request(-300000, 1023, 8));
        settle_block();
        program_reg(REG_CPS, 32'd4095);
        offer_request(make_request(-262144, 1023, 1));

        // Long run: build up phase at the largest period, then drop it
        settle_block();
        program_reg(REG_CPS, 32'hFFFF_FFFF);
        offer_request(make_request(524287, 1023, 2));
        offer_request(make_request(-4000, 1023, 2));
        offer_request(make_request(250000, 1023, 2));
        offer_request(make_request(-524288, 1023, 2));
        offer_request(make_request(77, 1023, 2));
        settle_block();
        program_reg(REG_CPS, 32'd4096);
        program_reg(REG_MUTE, 32'hFFFF_FFFF);
        offer_request(make_request(0, 0, 3));
        offer_request(make_request(5, 0, 3));
        // held value survives mute; no ticks since the last sample
        settle_block();
        program_reg(REG_MUTE, 32'hFFFF_FFFE);
        offer_request(make_request(-9, 0, 1));
        offer_request(make_request(9, 0, 1));
        offer_request(make_request(0, 0, 9));
        offer_request(make_request(1, 0, 1));

        // Random phases under changing settings
        for (int p = 0; p < 8; p++) begin
            settle_block();
            case (p)
                0:       cps_val = 32'd11609;
                2, 6:    cps_val = $urandom_range(0, 8191);
                3:       cps_val = $urandom_range(20000, 400000);
                7:       cps_val = $urandom();
                default: cps_val = $urandom_range(4096, 30000);
            endcase
            program_reg(REG_CPS, cps_val);
            word    = $urandom();
            word[0] = ($urandom_range(0, 3) == 0);
            program_reg(REG_MUTE, word);
            // long receiver hold-off while requests keep coming
            if (p == 2) begin
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            for (int i = 0; i < 55; i++)
                offer_request(random_request());
        end

        settle_block();
        repeat (64) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d samples never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("tb_tick_weighted_averaging_resampler passed");
        else
            $display("tb_tick_weighted_averaging_resampler failed");
        $finish;
    end

endmodule
